[rtl/core/hrv_pkg.sv]
`timescale 1ns / 1ps

package hrv_pkg;

   localparam int WINDOW_DEF  = 20;
   localparam int RR_W        = 16;
   localparam int RMS_W       = 20;
   localparam int PAIRS_W     = 6;
   localparam int SUM_W       = 38;
   localparam int SQ_W        = 2 * RR_W;
   localparam int FRAC_SHIFT  = 8;
   localparam int QUO_W       = SUM_W + FRAC_SHIFT;
   localparam int ROOT_W      = QUO_W / 2;
   localparam int REM_W       = ROOT_W + 1;
   localparam int STEP_W      = $clog2(QUO_W);
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 32;

endpackage

[rtl/core/hrv_ram.sv]
`timescale 1ns / 1ps

module hrv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 20
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/hrv_root_unit.sv]
`timescale 1ns / 1ps

module hrv_root_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [hrv_pkg::SUM_W-1:0]   square_sum,
   input  logic [hrv_pkg::PAIRS_W-1:0] pairs,
   output logic                        done,
   output logic [hrv_pkg::RMS_W-1:0]   root
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_ROOT
   } state_type;

   state_type                     state_ff;
   logic                          done_ff;
   logic [hrv_pkg::STEP_W-1:0]    step_ff;
   logic [hrv_pkg::QUO_W-1:0]     shift_ff;
   logic [hrv_pkg::PAIRS_W-1:0]   dvsr_ff;
   logic [hrv_pkg::PAIRS_W-1:0]   drem_ff;
   logic [hrv_pkg::REM_W-1:0]     rrem_ff;
   logic [hrv_pkg::ROOT_W-1:0]    root_ff;

   logic [hrv_pkg::PAIRS_W:0]     d_trial;
   logic [hrv_pkg::PAIRS_W:0]     d_dvsr;
   logic [hrv_pkg::PAIRS_W:0]     d_diff;
   logic                          d_ge;
   logic [hrv_pkg::REM_W+1:0]     r_trial;
   logic [hrv_pkg::REM_W+1:0]     r_test;
   logic [hrv_pkg::REM_W+1:0]     r_diff;
   logic                          r_ge;

   always_comb begin
      d_trial = {drem_ff, shift_ff[hrv_pkg::QUO_W-1]};
      d_dvsr  = {1'b0, dvsr_ff};
      d_ge    = (d_trial >= d_dvsr);
      d_diff  = d_trial - d_dvsr;
      r_trial = {rrem_ff, shift_ff[hrv_pkg::QUO_W-1 -: 2]};
      r_test  = {1'b0, root_ff, 2'b01};
      r_ge    = (r_trial >= r_test);
      r_diff  = r_trial - r_test;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               done_ff <= start && (pairs == '0);
               if (start) begin
                  shift_ff <= {square_sum, {hrv_pkg::FRAC_SHIFT{1'b0}}};
                  dvsr_ff  <= pairs;
                  drem_ff  <= '0;
                  rrem_ff  <= '0;
                  root_ff  <= '0;
                  step_ff  <= '0;
                  if (pairs != '0) begin
                     state_ff <= ST_DIVIDE;
                  end
               end
            end
            ST_DIVIDE: begin
               done_ff  <= 1'b0;
               shift_ff <= {shift_ff[hrv_pkg::QUO_W-2:0], d_ge};
               drem_ff  <= d_ge ? d_diff[hrv_pkg::PAIRS_W-1:0]
                                : d_trial[hrv_pkg::PAIRS_W-1:0];
               if (step_ff == hrv_pkg::STEP_W'(hrv_pkg::QUO_W - 1)) begin
                  step_ff  <= '0;
                  state_ff <= ST_ROOT;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_ROOT: begin
               shift_ff <= {shift_ff[hrv_pkg::QUO_W-3:0], 2'b00};
               rrem_ff  <= r_ge ? r_diff[hrv_pkg::REM_W-1:0]
                                : r_trial[hrv_pkg::REM_W-1:0];
               root_ff  <= {root_ff[hrv_pkg::ROOT_W-2:0], r_ge};
               done_ff  <= (step_ff == hrv_pkg::STEP_W'(hrv_pkg::ROOT_W - 1));
               if (step_ff == hrv_pkg::STEP_W'(hrv_pkg::ROOT_W - 1)) begin
                  state_ff <= ST_IDLE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            default: begin
               done_ff  <= 1'b0;
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign done = done_ff;
   assign root = root_ff[hrv_pkg::RMS_W-1:0];

endmodule

[rtl/core/hrv_rmssd_window.sv]
`timescale 1ns / 1ps

// Channel  Direction  Ports                         Contents
// req      in         req_tvalid/tready/tdata[15:0] rr_ms
// rsp      out        rsp_tvalid/tready/tdata[31:0] rmssd_q4, pairs_used
//
// An item passes through ring access and square update, then a bit-serial
// divider (46 steps) and a bit-serial square root (23 steps) that form the
// RMSSD result.
// One item is in work at a time; req_tready is high only while idle.
// A finished result waits in the output register; a stalled rsp holds the
// sequencer before loading, never the next input transfer.
// Synchronous active-high reset clears control state; the ring needs none.

module hrv_rmssd_window #(
   parameter int WINDOW = hrv_pkg::WINDOW_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [hrv_pkg::REQ_DATA_W-1:0] req_tdata,  // [15:0] rr_ms
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [hrv_pkg::RSP_DATA_W-1:0] rsp_tdata   // [19:0] rmssd_q4, [25:20] pairs_used
);

   localparam int SLOT_W = $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_OLD,
      ST_RD_NXT,
      ST_SQ_ADD,
      ST_SQ_SUB,
      ST_UPDATE,
      ST_LAUNCH,
      ST_WAIT
   } state_type;

   state_type                          state_ff;
   logic [SLOT_W-1:0]                  slot_ff;
   logic [CNT_W-1:0]                   count_ff;
   logic [hrv_pkg::SUM_W-1:0]          sum_ff;
   logic [hrv_pkg::RR_W-1:0]           rr_ff;
   logic [hrv_pkg::RR_W-1:0]           last_ff;
   logic [hrv_pkg::RR_W-1:0]           oldest_ff;
   logic [hrv_pkg::RR_W-1:0]           next_ff;
   logic [hrv_pkg::SQ_W-1:0]           prod_ff;
   logic                               has_prev_ff;
   logic                               full_ff;
   logic [hrv_pkg::PAIRS_W-1:0]        pairs_ff;
   logic                               rsp_valid_ff;
   logic [hrv_pkg::RSP_DATA_W-1:0]     rsp_data_ff;
   logic                               result_ready_ff;
   logic [hrv_pkg::RMS_W-1:0]          rms_ff;

   logic [SLOT_W-1:0]                  next_slot;
   logic [SLOT_W-1:0]                  rd_addr;
   logic [hrv_pkg::RR_W-1:0]           rd_data;
   logic                               wr_en;
   logic [hrv_pkg::RR_W-1:0]           diff_a;
   logic [hrv_pkg::RR_W-1:0]           diff_b;
   logic [hrv_pkg::RR_W-1:0]           diff_abs;
   logic [CNT_W-1:0]                   count_in;
   logic                               root_start;
   logic                               root_done;
   logic [hrv_pkg::RMS_W-1:0]          root_val;
   logic                               rsp_load;

   always_comb begin
      next_slot  = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
      rd_addr    = (state_ff == ST_RD_NXT) ? next_slot : slot_ff;
      wr_en      = (state_ff == ST_UPDATE);
      root_start = (state_ff == ST_LAUNCH);
      rsp_load   = (state_ff == ST_WAIT) && result_ready_ff
                   && (!rsp_valid_ff || rsp_tready);
      if (state_ff == ST_SQ_SUB) begin
         diff_a = next_ff;
         diff_b = oldest_ff;
      end else begin
         diff_a = rr_ff;
         diff_b = last_ff;
      end
      diff_abs = (diff_a >= diff_b) ? diff_a - diff_b : diff_b - diff_a;
      count_in = full_ff ? count_ff : count_ff + 1'b1;
   end

   hrv_ram #(
      .WIDTH (hrv_pkg::RR_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (rr_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hrv_root_unit u_root (
      .clock      (clock),
      .reset      (reset),
      .start      (root_start),
      .square_sum (sum_ff),
      .pairs      (pairs_ff),
      .done       (root_done),
      .root       (root_val)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         slot_ff         <= '0;
         count_ff        <= '0;
         sum_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         result_ready_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  rr_ff       <= req_tdata[hrv_pkg::RR_W-1:0];
                  has_prev_ff <= (count_ff != '0);
                  full_ff     <= (count_ff == CNT_W'(WINDOW));
                  state_ff    <= ST_RD_OLD;
               end
            end
            ST_RD_OLD: begin
               state_ff <= ST_RD_NXT;
            end
            ST_RD_NXT: begin
               oldest_ff <= rd_data;
               state_ff  <= ST_SQ_ADD;
            end
            ST_SQ_ADD: begin
               next_ff  <= rd_data;
               prod_ff  <= diff_abs * diff_abs;
               state_ff <= ST_SQ_SUB;
            end
            ST_SQ_SUB: begin
               if (has_prev_ff) begin
                  sum_ff <= sum_ff + hrv_pkg::SUM_W'(prod_ff);
               end
               prod_ff  <= diff_abs * diff_abs;
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               if (full_ff) begin
                  sum_ff <= sum_ff - hrv_pkg::SUM_W'(prod_ff);
               end
               slot_ff  <= next_slot;
               count_ff <= count_in;
               last_ff  <= rr_ff;
               pairs_ff <= hrv_pkg::PAIRS_W'(count_in - 1'b1);
               state_ff <= ST_LAUNCH;
            end
            ST_LAUNCH: begin
               result_ready_ff <= 1'b0;
               state_ff        <= ST_WAIT;
            end
            ST_WAIT: begin
               if (root_done) begin
                  rms_ff          <= root_val;
                  result_ready_ff <= 1'b1;
               end
               if (rsp_load) begin
                  rsp_data_ff  <= {{(hrv_pkg::RSP_DATA_W - hrv_pkg::RMS_W
                                     - hrv_pkg::PAIRS_W){1'b0}},
                                   pairs_ff, rms_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[bench/tb_hrv_rmssd_window.sv]
`timescale 1ns / 1ps

module tb_hrv_rmssd_window;

   typedef struct packed {
      logic [hrv_pkg::RMS_W-1:0]   rmssd_q4;
      logic [hrv_pkg::PAIRS_W-1:0] pairs_used;
   } rmssd_result_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [hrv_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [hrv_pkg::RSP_DATA_W-1:0] rsp_tdata;

   logic [hrv_pkg::RR_W-1:0] rr_ring [hrv_pkg::WINDOW_DEF];
   int                       next_slot;
   int                       held_count;
   rmssd_result_type         rmssd_due [$];
   int                       fail_count;
   bit                       tail_steady;
   int                       hold_cnt;

   hrv_rmssd_window uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint unsigned root_floor(input longint unsigned v);
      longint unsigned rem;
      longint unsigned res;
      longint unsigned b;
      rem = v;
      res = 0;
      b = 64'd1 << 62;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
         if (rem >= res + b) begin
            rem = rem - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Store the interval, then rebuild the squared-difference sum in arrival order.
   task automatic hrv_predict(input logic [hrv_pkg::RR_W-1:0] rr);
      longint unsigned  sq_sum;
      longint unsigned  diff;
      int               oldest;
      int               pairs;
      int               a;
      int               b;
      rmssd_result_type want;
      rr_ring[next_slot] = rr;
      next_slot = (next_slot + 1) % hrv_pkg::WINDOW_DEF;
      if (held_count < hrv_pkg::WINDOW_DEF) held_count++;
      oldest = (next_slot + hrv_pkg::WINDOW_DEF - held_count) % hrv_pkg::WINDOW_DEF;
      sq_sum = 0;
      for (int i = 1; i < held_count; i++) begin
         a = (oldest + i - 1) % hrv_pkg::WINDOW_DEF;
         b = (oldest + i) % hrv_pkg::WINDOW_DEF;
         diff = (rr_ring[b] >= rr_ring[a]) ? rr_ring[b] - rr_ring[a]
                                           : rr_ring[a] - rr_ring[b];
         sq_sum += diff * diff;
      end
      pairs = (held_count >= 2) ? held_count - 1 : 0;
      want.pairs_used = hrv_pkg::PAIRS_W'(pairs);
      if (pairs == 0) begin
         want.rmssd_q4 = '0;
      end else begin
         want.rmssd_q4 = hrv_pkg::RMS_W'(root_floor((sq_sum << hrv_pkg::FRAC_SHIFT)
                                                    / longint'(pairs)));
      end
      rmssd_due.push_back(want);
   endtask

   task automatic send_interval(input logic [hrv_pkg::RR_W-1:0] rr);
      if (!tail_steady && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rr;
      do @(posedge clock); while (!req_tready);
      hrv_predict(rr);
   endtask

   function automatic logic [hrv_pkg::RR_W-1:0] clamp_rr(input int v);
      if (v < 0) return '0;
      if (v > 65535) return 16'hFFFF;
      return hrv_pkg::RR_W'(v);
   endfunction

   // First item after reset, max swing, ring fill and wrap.
   task automatic test_extreme_swing();
      for (int i = 0; i < 22; i++) send_interval((i % 2 == 0) ? 16'h0000 : 16'hFFFF);
   endtask

   task automatic test_random_rhythms(input int n_items);
      int sent;
      int run_len;
      int kind;
      int level;
      logic [hrv_pkg::RR_W-1:0] flat;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            // resting rhythm with beat-to-beat jitter
            level = $urandom_range(300, 2000);
            run_len = $urandom_range(10, 60);
            for (int i = 0; i < run_len; i++) begin
               level = level + $urandom_range(0, 100) - 50;
               send_interval(clamp_rr(level));
            end
         end else if (kind < 7) begin
            run_len = $urandom_range(1, 30);
            for (int i = 0; i < run_len; i++) begin
               send_interval(hrv_pkg::RR_W'($urandom_range(0, 65535)));
            end
         end else if (kind < 9) begin
            // flat run flushes the window down to zero once it spans the full window
            flat = hrv_pkg::RR_W'($urandom_range(0, 65535));
            run_len = $urandom_range(18, 25);
            for (int i = 0; i < run_len; i++) send_interval(flat);
         end else begin
            run_len = $urandom_range(1, 25);
            for (int i = 0; i < run_len; i++) begin
               case ($urandom_range(0, 4))
                  0: send_interval(16'h0000);
                  1: send_interval(16'hFFFF);
                  2: send_interval(16'h0001);
                  3: send_interval(16'h8000);
                  default: send_interval(16'h7FFF);
               endcase
            end
         end
         sent += run_len;
      end
   endtask

   task automatic test_drain_pause();
      test_random_rhythms(30);
      req_tvalid <= 1'b0;
      wait (rmssd_due.size() == 0);
      @(posedge clock);
      test_random_rhythms(30);
   endtask

   task automatic test_back_to_back();
      tail_steady = 1'b1;
      test_random_rhythms(300);
   endtask

   initial begin
      rsp_tready <= 1'b0;
      hold_cnt = 0;
      forever begin
         @(posedge clock);
         if (hold_cnt != 0) begin
            hold_cnt--;
         end else if (!tail_steady && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            hold_cnt = $urandom_range(0, 14);
         end else begin
            rsp_tready <= 1'b1;
            hold_cnt = $urandom_range(0, 19);
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      rmssd_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rmssd_due.size() == 0) begin
            $display("%0t unexpected rsp transfer: expected none, actual %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = rmssd_due.pop_front();
            if (rsp_tdata[19:0] !== want.rmssd_q4) begin
               $display("%0t rmssd_q4 expected %0d actual %0d", $time, want.rmssd_q4,
                        rsp_tdata[19:0]);
               fail_count++;
            end
            if (rsp_tdata[25:20] !== want.pairs_used) begin
               $display("%0t pairs_used expected %0d actual %0d", $time, want.pairs_used,
                        rsp_tdata[25:20]);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #20000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      fail_count  = 0;
      tail_steady = 1'b0;
      next_slot   = 0;
      held_count  = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extreme_swing();
      test_random_rhythms(1600);
      test_drain_pause();
      test_back_to_back();
      req_tvalid <= 1'b0;
      wait (rmssd_due.size() == 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
